/* rtl/acc_pkg.sv */
// ---------------------------------------------------------------------------
// Audio codec control package
// Shared types, register offsets, field constants and helper functions.
// ---------------------------------------------------------------------------
package acc_pkg;

   // Beat kinds on the request channel.
   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_USEC  = 2'd2,
      MODE_FRAME = 2'd3
   } mode_type;

   // Source of the read response word.
   typedef enum logic [2:0] {
      SEL_SOUND  = 3'd0,
      SEL_CODEC  = 3'd1,
      SEL_STATUS = 3'd2,
      SEL_FRAME  = 3'd3,
      SEL_BAD    = 3'd4
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       sound_we;
      logic       codec_we;
      logic       codec_done;
      logic       frame_we;
      logic       frame_inc;
      logic       usec_tick;
      logic       rsp_load;
      rd_sel_type rd_sel;
   } acc_cmd_type;

   localparam logic [7:0]  OFS_SOUND   = 8'h00;
   localparam logic [7:0]  OFS_CODEC   = 8'h10;
   localparam logic [7:0]  OFS_STATUS  = 8'h20;

   localparam logic [31:0] CC_BUSY     = 32'h0100_0000;
   localparam int          CC_WRITE_BIT = 21;
   localparam logic [31:0] ST_READY    = 32'h0040_0000;
   localparam logic [31:0] ST_VALID    = 32'h0080_0000;
   localparam logic [31:0] REG1_RESET  = 32'h0101_0000;
   localparam logic [9:0]  DELAY_RESET = 10'd22;

   // Bus words arrive and leave in the opposite byte order.
   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // Value an internal codec register holds before its first write.
   function automatic logic [31:0] reset_word(input logic [7:0] addr);
      return (addr == 8'd1) ? REG1_RESET : 32'h0;
   endfunction

endpackage

/* rtl/acc_req_if.sv */
// ---------------------------------------------------------------------------
// Request channel
// Carries one bus access or tick per beat.
// ---------------------------------------------------------------------------
interface acc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  reg_offset;
   logic [31:0] write_data;

   modport source (output valid, output mode, output reg_offset, output write_data,
                   input ready);
   modport sink   (input valid, input mode, input reg_offset, input write_data,
                   output ready);
endinterface

/* rtl/acc_rsp_if.sv */
// ---------------------------------------------------------------------------
// Response channel
// Carries one read result per beat.
// ---------------------------------------------------------------------------
interface acc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        bad_offset;

   modport source (output valid, output read_data, output bad_offset, input ready);
   modport sink   (input valid, input read_data, input bad_offset, output ready);
endinterface

/* rtl/acc_datapath.sv */
// ---------------------------------------------------------------------------
// Audio codec control datapath
// Register storage, codec register file, countdown and response register.
// ---------------------------------------------------------------------------
module acc_datapath #(
   parameter int NUM_CODEC_REGS = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  acc_pkg::acc_cmd_type cmd,
   input  logic [31:0]         write_data,
   input  logic                csr_we,
   input  logic [9:0]          csr_wdata,
   output logic [31:0]         read_data,
   output logic                bad_offset
);
   import acc_pkg::*;

   localparam int AW = $clog2(NUM_CODEC_REGS);

   logic [31:0] mem [NUM_CODEC_REGS];
   logic [NUM_CODEC_REGS-1:0] wr_ok_ff, wr_ok_in;

   logic [9:0]  delay_ff, delay_in;
   logic [31:0] sound_ff, sound_in;
   logic [31:0] cmd_ff, cmd_in;
   logic [31:0] frame_ff, frame_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  lane_ff, lane_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        vflag_ff, vflag_in;
   logic [9:0]  down_ff, down_in;
   logic [31:0] rd_data_ff;
   logic        rd_ok_ff, rd_ok_in;
   logic [31:0] read_data_ff, read_data_in;
   logic        bad_ff, bad_in;

   logic [31:0] wr_word, base, merged, status, clr_mask;
   logic [7:0]  cc_addr, cc_data;
   logic [1:0]  cc_lane;
   logic [4:0]  cc_shift;
   logic        cc_write, in_range, mem_we;
   logic [AW-1:0] new_idx, cc_idx;

   always_comb begin
      wr_word  = swap32(write_data);
      new_idx  = wr_word[AW+11:12];
      cc_data  = cmd_ff[7:0];
      cc_lane  = cmd_ff[9:8];
      cc_addr  = cmd_ff[19:12];
      cc_idx   = cc_addr[AW-1:0];
      cc_write = cmd_ff[CC_WRITE_BIT];
      cc_shift = {cc_lane, 3'b000};
      in_range = {1'b0, cc_addr} < 9'(NUM_CODEC_REGS);
      base     = rd_ok_ff ? rd_data_ff : reset_word(cc_addr);
      clr_mask = ~(32'h0000_00FF << cc_shift);
      merged   = (base & clr_mask) | ({24'h0, cc_data} << cc_shift);
      mem_we   = cmd.codec_done && cc_write && in_range;
      status   = ST_READY | (vflag_ff ? ST_VALID : 32'h0) | ({30'h0, cnt_ff} << 14) |
                 ({30'h0, lane_ff} << 12) | ({24'h0, byte_ff} << 4);

      delay_in     = csr_we ? csr_wdata : delay_ff;
      sound_in     = cmd.sound_we ? wr_word : sound_ff;
      cmd_in       = cmd.codec_we ? (wr_word & ~CC_BUSY) : cmd_ff;
      frame_in     = frame_ff;
      byte_in      = byte_ff;
      lane_in      = lane_ff;
      cnt_in       = cnt_ff;
      vflag_in     = vflag_ff;
      down_in      = down_ff;
      rd_ok_in     = cmd.codec_we ? wr_ok_ff[new_idx] : rd_ok_ff;
      wr_ok_in     = wr_ok_ff;
      read_data_in = read_data_ff;
      bad_in       = bad_ff;

      if (cmd.frame_we) begin
         frame_in = wr_word;
      end else if (cmd.frame_inc) begin
         frame_in = frame_ff + 32'd1;
      end

      if (mem_we) begin
         wr_ok_in[cc_idx] = 1'b1;
      end

      // A codec read latches one lane and restarts the countdown.
      if (cmd.codec_done && !cc_write) begin
         byte_in  = in_range ? 8'(base >> cc_shift) : 8'h00;
         lane_in  = cc_lane;
         vflag_in = 1'b1;
         down_in  = (delay_ff == 10'd0) ? 10'd1 : delay_ff;
      end else if (cmd.usec_tick && down_ff != 10'd0) begin
         down_in = down_ff - 10'd1;
         if (down_ff == 10'd1) begin
            vflag_in = 1'b0;
            cnt_in   = cnt_ff + 2'd1;
         end
      end

      if (cmd.rsp_load) begin
         bad_in = 1'b0;
         case (cmd.rd_sel)
            SEL_SOUND:  read_data_in = swap32(sound_ff);
            SEL_CODEC:  read_data_in = swap32(cmd_ff);
            SEL_STATUS: read_data_in = swap32(status);
            SEL_FRAME:  read_data_in = swap32(frame_ff);
            default: begin
               read_data_in = 32'h0;
               bad_in       = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.codec_we) begin
         rd_data_ff <= mem[new_idx];
      end
      if (mem_we) begin
         mem[cc_idx] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      bad_ff       <= bad_in;
      if (reset) begin
         delay_ff <= DELAY_RESET;
         sound_ff <= '0;
         cmd_ff   <= '0;
         frame_ff <= '0;
         byte_ff  <= '0;
         lane_ff  <= '0;
         cnt_ff   <= '0;
         vflag_ff <= 1'b0;
         down_ff  <= '0;
         rd_ok_ff <= 1'b0;
         wr_ok_ff <= '0;
      end else begin
         delay_ff <= delay_in;
         sound_ff <= sound_in;
         cmd_ff   <= cmd_in;
         frame_ff <= frame_in;
         byte_ff  <= byte_in;
         lane_ff  <= lane_in;
         cnt_ff   <= cnt_in;
         vflag_ff <= vflag_in;
         down_ff  <= down_in;
         rd_ok_ff <= rd_ok_in;
         wr_ok_ff <= wr_ok_in;
      end
   end

   assign read_data  = read_data_ff;
   assign bad_offset = bad_ff;

   a_expire_clears_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.usec_tick && !cmd.codec_done && down_ff == 10'd1 |=> !vflag_ff && down_ff == 10'd0)
      else $error("countdown expiry did not clear the first-valid flag");

   a_read_arms_countdown: assert property (@(posedge clock) disable iff (reset)
      cmd.codec_done && !cc_write |=> vflag_ff && down_ff != 10'd0)
      else $error("codec read did not arm the countdown");

   a_bad_read_is_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && cmd.rd_sel == SEL_BAD |=> bad_ff && read_data_ff == 32'h0)
      else $error("unsupported read did not return zero with the error flag");

endmodule

/* rtl/acc_ctrl.sv */
// ---------------------------------------------------------------------------
// Audio codec control sequencer
// Decodes request beats into datapath commands and owns the handshakes.
// ---------------------------------------------------------------------------
module acc_ctrl #(
   parameter int FRAME_COUNT_OFFSET = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   input  logic [7:0]           req_reg_offset,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output acc_pkg::acc_cmd_type cmd
);
   import acc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_CODEC = 2'b10
   } state_type;

   localparam logic [7:0] OFS_FRAME = 8'(FRAME_COUNT_OFFSET);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   mode_type  mode;

   always_comb begin
      mode      = mode_type'(req_mode);
      req_ready = (state_ff == ST_IDLE) &&
                  (!rsp_valid_ff || rsp_ready || mode != MODE_READ);
      accept    = req_valid && req_ready;

      cmd          = '0;
      cmd.rd_sel   = SEL_BAD;
      state_in     = state_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode)
                  MODE_READ: begin
                     cmd.rsp_load = 1'b1;
                     if (req_reg_offset == OFS_SOUND) begin
                        cmd.rd_sel = SEL_SOUND;
                     end else if (req_reg_offset == OFS_CODEC) begin
                        cmd.rd_sel = SEL_CODEC;
                     end else if (req_reg_offset == OFS_STATUS) begin
                        cmd.rd_sel = SEL_STATUS;
                     end else if (req_reg_offset == OFS_FRAME) begin
                        cmd.rd_sel = SEL_FRAME;
                     end
                  end
                  MODE_WRITE: begin
                     if (req_reg_offset == OFS_SOUND) begin
                        cmd.sound_we = 1'b1;
                     end else if (req_reg_offset == OFS_CODEC) begin
                        cmd.codec_we = 1'b1;
                        state_in     = ST_CODEC;
                     end else if (req_reg_offset != OFS_STATUS &&
                                  req_reg_offset == OFS_FRAME) begin
                        cmd.frame_we = 1'b1;
                     end
                  end
                  MODE_USEC:  cmd.usec_tick = 1'b1;
                  MODE_FRAME: cmd.frame_inc = 1'b1;
                  default:    cmd.rsp_load  = 1'b0;
               endcase
            end
         end
         ST_CODEC: begin
            cmd.codec_done = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_codec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CODEC |=> state_ff == ST_IDLE)
      else $error("codec update stayed longer than one cycle");

   a_codec_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CODEC |-> !req_ready && cmd.codec_done)
      else $error("request taken during codec update");

   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && mode == MODE_READ |=> rsp_valid_ff)
      else $error("accepted read produced no response");

endmodule

/* rtl/audio_codec_control_registers.sv */
// ---------------------------------------------------------------------------
// Audio codec control registers
// Host-side register interface of a sound codec: sound control, codec
// command and status, frame counter, and an internal codec register file.
// ---------------------------------------------------------------------------
// A read beat's response is registered and valid in the cycle after acceptance.
// One beat per cycle while no held response blocks a read, except a
// codec-control write, which holds off the next beat because the codec
// register file is read and then updated through its single registered port.
// Reset is synchronous and active high; the register file needs no clearing
// pass, since per-entry written bits fall back to the reset contents.
// ---------------------------------------------------------------------------
module audio_codec_control_registers #(
   parameter int NUM_CODEC_REGS     = 128,
   parameter int FRAME_COUNT_OFFSET = 48
) (
   input  logic        clock,
   input  logic        reset,
   acc_req_if.sink     req,
   acc_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata
);
   import acc_pkg::*;

   // The controller decodes each request beat into one command set for the
   // datapath. Reads are answered from the response register; ticks and plain
   // writes complete in the cycle they are accepted.
   acc_cmd_type cmd;

   acc_ctrl #(
      .FRAME_COUNT_OFFSET(FRAME_COUNT_OFFSET)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_mode      (req.mode),
      .req_reg_offset(req.reg_offset),
      .req_ready     (req.ready),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .cmd           (cmd)
   );

   // The datapath holds all architectural state, including the countdown
   // register that is loaded from the first-valid delay setting.
   acc_datapath #(
      .NUM_CODEC_REGS(NUM_CODEC_REGS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .write_data(req.write_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .read_data (rsp.read_data),
      .bad_offset(rsp.bad_offset)
   );

endmodule

/* test/audio_codec_control_registers_scoreboard.sv */
// ---------------------------------------------------------------------------
// Audio codec control registers scoreboard
// Watches the request, response and CSR ports, keeps its own copy of the
// register state and compares every read response with the predicted word.
// ---------------------------------------------------------------------------
module audio_codec_control_registers_scoreboard #(
   parameter int NUM_CODEC_REGS     = 128,
   parameter int FRAME_COUNT_OFFSET = 48
) (
   input  logic       clock,
   input  logic       reset,
   acc_req_if         req,
   acc_rsp_if         rsp,
   input  logic       csr_we,
   input  logic [9:0] csr_wdata,
   output int         mismatch_count,
   output int         reads_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import acc_pkg::*;

   typedef struct packed {
      logic [31:0] read_data;
      logic        bad_offset;
   } read_result_type;

   read_result_type expected_reads [$];

   // Shadow copy of the block's state.
   logic [31:0] sound_word;
   logic [31:0] codec_cmd_word;
   logic [31:0] frame_shadow;
   logic [31:0] codec_file [NUM_CODEC_REGS];
   logic [7:0]  held_byte;
   logic [1:0]  held_lane;
   logic [1:0]  lane_count;
   logic        valid_bit;
   logic [9:0]  countdown;
   logic [9:0]  delay_setting;
   int          errors = 0;

   function automatic logic [31:0] byte_reverse(input logic [31:0] w);
      logic [31:0] r;
      r = {<<8{w}};
      return r;
   endfunction

   function automatic void report_mismatch(input string what, input logic [31:0] want,
                                           input logic [31:0] got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
   endfunction

   always @(posedge clock) begin : predict_and_compare
      read_result_type seen;
      read_result_type want;
      logic [31:0]     word;
      logic [31:0]     cmd;
      logic [7:0]      addr;
      logic [1:0]      lane;

      if (reset) begin
         sound_word     = '0;
         codec_cmd_word = '0;
         frame_shadow   = '0;
         for (int i = 0; i < NUM_CODEC_REGS; i++)
            codec_file[i] = (i == 1) ? REG1_RESET : 32'h0;
         held_byte     = '0;
         held_lane     = '0;
         lane_count    = '0;
         valid_bit     = 1'b0;
         countdown     = '0;
         delay_setting = DELAY_RESET;
         expected_reads.delete();
      end else begin
         if (csr_we)
            delay_setting = csr_wdata;

         // Compare the response beat first; a read accepted at this edge
         // cannot answer in the same cycle.
         if (rsp.valid && rsp.ready) begin
            seen.read_data  = rsp.read_data;
            seen.bad_offset = rsp.bad_offset;
            if (expected_reads.size() == 0) begin
               report_mismatch("response beat with no read pending", 32'h0, seen.read_data);
            end else begin
               want = expected_reads.pop_front();
               if (seen.read_data !== want.read_data)
                  report_mismatch("read_data", want.read_data, seen.read_data);
               if (seen.bad_offset !== want.bad_offset)
                  report_mismatch("bad_offset", 32'(want.bad_offset), 32'(seen.bad_offset));
            end
         end

         if (req.valid && req.ready) begin
            case (mode_type'(req.mode))
               MODE_READ: begin
                  want.bad_offset = 1'b0;
                  if (req.reg_offset == OFS_SOUND) begin
                     word = sound_word;
                  end else if (req.reg_offset == OFS_CODEC) begin
                     word = codec_cmd_word;
                  end else if (req.reg_offset == OFS_STATUS) begin
                     word = ST_READY;
                     word[11:4]  = held_byte;
                     word[13:12] = held_lane;
                     word[15:14] = lane_count;
                     if (valid_bit)
                        word = word | ST_VALID;
                  end else if (req.reg_offset == 8'(FRAME_COUNT_OFFSET)) begin
                     word = frame_shadow;
                  end else begin
                     word = 32'h0;
                     want.bad_offset = 1'b1;
                  end
                  want.read_data = byte_reverse(word);
                  expected_reads.push_back(want);
               end
               MODE_WRITE: begin
                  cmd = byte_reverse(req.write_data);
                  if (req.reg_offset == OFS_SOUND) begin
                     sound_word = cmd;
                  end else if (req.reg_offset == OFS_CODEC) begin
                     codec_cmd_word = cmd & ~CC_BUSY;
                     addr = cmd[19:12];
                     lane = cmd[9:8];
                     if (cmd[CC_WRITE_BIT]) begin
                        if (addr < NUM_CODEC_REGS)
                           codec_file[addr][8*lane +: 8] = cmd[7:0];
                     end else begin
                        word = (addr < NUM_CODEC_REGS) ? codec_file[addr] : 32'h0;
                        held_byte = word[8*lane +: 8];
                        held_lane = lane;
                        valid_bit = 1'b1;
                        countdown = (delay_setting == 10'd0) ? 10'd1 : delay_setting;
                     end
                  end else if (req.reg_offset == OFS_STATUS) begin
                     // Status is read only.
                  end else if (req.reg_offset == 8'(FRAME_COUNT_OFFSET)) begin
                     frame_shadow = cmd;
                  end
               end
               MODE_USEC: begin
                  if (countdown != 10'd0) begin
                     countdown = countdown - 10'd1;
                     if (countdown == 10'd0) begin
                        valid_bit  = 1'b0;
                        lane_count = lane_count + 2'd1;
                     end
                  end
               end
               MODE_FRAME: begin
                  frame_shadow = frame_shadow + 32'd1;
               end
               default: begin
               end
            endcase
         end
      end

      mismatch_count <= errors;
      reads_pending  <= expected_reads.size();
   end

endmodule

/* test/audio_codec_control_registers_test.sv */
// ---------------------------------------------------------------------------
// Audio codec control registers testbench
// Drives bus reads, bus writes, microsecond ticks and frame ticks with random
// idle cycles on both channels, walks the first-valid delay through several
// settings, and lets the scoreboard check every read response.
// ---------------------------------------------------------------------------
module audio_codec_control_registers_test;
   timeunit 1ns;
   timeprecision 1ps;
   import acc_pkg::*;

   localparam int         NUM_CODEC_REGS     = 128;
   localparam int         FRAME_COUNT_OFFSET = 48;
   localparam logic [7:0] OFS_FRAME          = 8'(FRAME_COUNT_OFFSET);
   // Random beats per delay setting. Together with the directed beats and the
   // full countdown at the largest delay, the run comes to roughly 1850 beats.
   localparam int         PHASE_BEATS        = 135;
   localparam int         PHASE_COUNT        = 6;
   // A codec-control write passes through the update state and a read answers
   // from the response register, so the settle time covers anything in flight.
   localparam int         SETTLE_CYCLES      = 4;
   localparam int         HOLD_CYCLES        = 300;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [9:0] csr_wdata;

   // When set, neither side inserts idle cycles.
   bit full_rate = 1'b0;
   // Raised by the stimulus to make the response side hold off for a while.
   bit rsp_hold_request = 1'b0;

   int mismatch_count;
   int reads_pending;

   acc_req_if req_if ();
   acc_rsp_if rsp_if ();

   audio_codec_control_registers #(
      .NUM_CODEC_REGS     (NUM_CODEC_REGS),
      .FRAME_COUNT_OFFSET (FRAME_COUNT_OFFSET)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   audio_codec_control_registers_scoreboard #(
      .NUM_CODEC_REGS     (NUM_CODEC_REGS),
      .FRAME_COUNT_OFFSET (FRAME_COUNT_OFFSET)
   ) u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .reads_pending  (reads_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case a handshake never completes or a read is never
   // answered. The slowest legal run is far below this.
   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Builds a codec-control word in bus byte order. The fields the block
   // decodes are placed explicitly; every other bit, busy included, is random.
   function automatic logic [31:0] codec_word(input bit is_write, input logic [7:0] addr,
                                              input logic [1:0] lane, input logic [7:0] data);
      logic [31:0] cmd;
      logic [31:0] bus;
      cmd = $urandom;
      cmd[7:0]          = data;
      cmd[9:8]          = lane;
      cmd[19:12]        = addr;
      cmd[CC_WRITE_BIT] = is_write;
      bus = {<<8{cmd}};
      return bus;
   endfunction

   // Offers one beat after a random gap and returns at the edge where it is
   // accepted. Valid is only lowered when a gap follows, so back-to-back
   // beats keep it high without a second assignment in the same step.
   task automatic send_beat(input mode_type mode, input logic [7:0] offset,
                            input logic [31:0] data);
      int gap;
      gap = full_rate ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.mode       <= mode;
      req_if.reg_offset <= offset;
      req_if.write_data <= data;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stops offering beats and waits until every predicted read response has
   // arrived, then the settle time for a codec write still in progress.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (reads_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: a random stall before each beat, plus one long hold-off
   // on request so that the block backs up and stalls its request channel.
   initial begin : response_sink
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = full_rate ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin : stimulus
      int         pick;
      int         beats;
      logic [7:0] ofs;
      logic [7:0] addr;
      logic [9:0] delay;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.mode       <= MODE_READ;
      req_if.reg_offset <= '0;
      req_if.write_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset delay setting.
      // Reset contents of every readable register, then two offsets that
      // name no register.
      send_beat(MODE_READ, OFS_SOUND, $urandom);
      send_beat(MODE_READ, OFS_CODEC, $urandom);
      send_beat(MODE_READ, OFS_STATUS, $urandom);
      send_beat(MODE_READ, OFS_FRAME, $urandom);
      send_beat(MODE_READ, 8'hFF, $urandom);
      send_beat(MODE_READ, 8'h01, $urandom);
      // Sound control holds any word; all ones and an asymmetric pattern
      // show both the storage and the byte swap.
      send_beat(MODE_WRITE, OFS_SOUND, 32'hFFFF_FFFF);
      send_beat(MODE_READ, OFS_SOUND, 32'h0);
      send_beat(MODE_WRITE, OFS_SOUND, 32'h1234_5678);
      send_beat(MODE_READ, OFS_SOUND, 32'h0);
      // Write the top lane of codec entry 1, then read a lane that still
      // holds its reset byte; the stored command must have busy cleared.
      send_beat(MODE_WRITE, OFS_CODEC, codec_word(1'b1, 8'd1, 2'd3, 8'hAB));
      send_beat(MODE_WRITE, OFS_CODEC, codec_word(1'b0, 8'd1, 2'd2, 8'h00));
      send_beat(MODE_READ, OFS_STATUS, $urandom);
      send_beat(MODE_READ, OFS_CODEC, $urandom);
      // Codec addresses past the end of the file: the write is dropped and
      // the read latches zero while still raising the flag.
      send_beat(MODE_WRITE, OFS_CODEC, codec_word(1'b1, 8'hFF, 2'd0, 8'h5A));
      send_beat(MODE_WRITE, OFS_CODEC, codec_word(1'b0, 8'hFF, 2'd1, 8'h00));
      send_beat(MODE_READ, OFS_STATUS, $urandom);
      send_beat(MODE_USEC, 8'h00, $urandom);
      // Writes to status and to an unused offset are ignored.
      send_beat(MODE_WRITE, OFS_STATUS, 32'hFFFF_FFFF);
      send_beat(MODE_WRITE, 8'h55, 32'hFFFF_FFFF);
      // Frame counter wraps from all ones to zero.
      send_beat(MODE_WRITE, OFS_FRAME, 32'hFFFF_FFFF);
      send_beat(MODE_FRAME, 8'hFF, 32'h0);
      send_beat(MODE_READ, OFS_FRAME, $urandom);
      // A new codec read while the countdown runs restarts it.
      send_beat(MODE_WRITE, OFS_CODEC, codec_word(1'b0, 8'd1, 2'd3, 8'h00));
      send_beat(MODE_READ, OFS_STATUS, $urandom);

      // Random part: one phase per delay setting, from the reset value through
      // one, the largest, zero, a random small one and three.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       delay = DELAY_RESET;
            1:       delay = 10'd1;
            2:       delay = 10'd1023;
            3:       delay = 10'd0;
            4:       delay = 10'($urandom_range(2, 40));
            default: delay = 10'd3;
         endcase

         // The delay register may only change while the block is idle, so
         // every earlier read must have been answered first.
         drain_results();
         if (phase > 0) begin
            csr_we    <= 1'b1;
            csr_wdata <= delay;
            @(posedge clock);
            csr_we    <= 1'b0;
         end

         // One phase runs with no idle cycles on either side.
         full_rate = (phase == 4);

         beats = 0;
         while (beats < PHASE_BEATS) begin
            // Ask for the long response hold-off once, midway through the phase
            // at a delay of one.
            if (phase == 1 && beats == PHASE_BEATS / 2)
               rsp_hold_request = 1'b1;

            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
               addr = 8'($urandom_range(NUM_CODEC_REGS, 255));
            else
               addr = 8'($urandom_range(0, NUM_CODEC_REGS - 1));

            if (pick < 30) begin
               send_beat(MODE_USEC, 8'($urandom), $urandom);
               beats++;
            end else if (pick < 38) begin
               send_beat(MODE_FRAME, 8'($urandom), $urandom);
               beats++;
            end else if (pick < 55) begin
               send_beat(MODE_WRITE, OFS_CODEC,
                         codec_word(1'($urandom), addr, 2'($urandom), 8'($urandom)));
               beats++;
            end else if (pick < 75) begin
               case ($urandom_range(0, 4))
                  0:       ofs = OFS_SOUND;
                  1:       ofs = OFS_CODEC;
                  2:       ofs = OFS_STATUS;
                  3:       ofs = OFS_FRAME;
                  default: ofs = 8'($urandom);
               endcase
               send_beat(MODE_READ, ofs, $urandom);
               beats++;
            end else if (pick < 85) begin
               send_beat(MODE_WRITE, $urandom_range(0, 1) ? OFS_SOUND : OFS_FRAME, $urandom);
               beats++;
            end else begin
               // Noise: a write at any offset. Ones that hit no register are
               // ignored by the block.
               ofs = 8'($urandom);
               send_beat(MODE_WRITE, ofs, $urandom);
               beats++;
            end
         end

         // At the largest delay random ticks never reach expiry, so run one
         // full countdown: the flag is still set one tick short of the end
         // and clears on the last tick.
         if (delay == 10'd1023) begin
            send_beat(MODE_WRITE, OFS_CODEC, codec_word(1'b0, 8'd1, 2'd2, 8'h00));
            repeat (1022) send_beat(MODE_USEC, 8'($urandom), $urandom);
            send_beat(MODE_READ, OFS_STATUS, $urandom);
            send_beat(MODE_USEC, 8'($urandom), $urandom);
            send_beat(MODE_READ, OFS_STATUS, $urandom);
         end
      end

      full_rate = 1'b0;
      drain_results();

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
